@@ rtl/mccst_pkg.sv @@
// Shared types, register indexes and constant curve tables for the MIDI CC mapper.
package mccst_pkg;

    localparam int TAB_BITS = 24;
    localparam int CFG_IDX_W = 4;
    localparam int CFG_DATA_W = 24;

    localparam logic [63:0] ONE_Q30 = 64'd1073741824;
    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
    localparam logic [63:0] LN2_Q30 = 64'd744261118;
    localparam logic [63:0] LN10_Q30 = 64'd2472381918;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SOURCE_CHANNEL = 4'd0,
        CFG_SOURCE_IS_CC   = 4'd1,
        CFG_SOURCE_NUMBER  = 4'd2,
        CFG_CURVE_MODE     = 4'd3,
        CFG_INVERT_ENABLE  = 4'd4,
        CFG_RANGE_LOW      = 4'd5,
        CFG_RANGE_HIGH     = 4'd6,
        CFG_PICKUP_ENABLE  = 4'd7
    } t_cfg_idx;

    typedef struct packed {
        logic load_in;
        logic eval;
        logic mul;
        logic sum;
        logic load_out;
    } t_cmd;

    typedef struct packed {
        logic out_free;
    } t_status;

    typedef logic [3:0][127:0][TAB_BITS:0] t_curve_tab;
    typedef logic [127:0][15:0] t_pos_tab;

    function automatic logic [63:0] udiv(input logic [63:0] n, input logic [63:0] d);
        logic [63:0] q;
        logic [63:0] r;
        q = '0;
        r = '0;
        for (int b = 63; b >= 0; b--) begin
            r = {r[62:0], n[b]};
            if (r >= d) begin
                r = r - d;
                q[b] = 1'b1;
            end
        end
        return q;
    endfunction

    function automatic logic [63:0] sin_q30(input logic [63:0] a);
        logic [63:0] a2;
        logic [63:0] term;
        logic signed [63:0] acc;
        a2 = (a * a) >> 30;
        term = a;
        acc = $signed(a);
        for (int k = 1; k <= 8; k++) begin
            term = (term * a2) >> 30;
            term = udiv(term, 64'((2 * k) * (2 * k + 1)));
            if ((k % 2) == 1) begin
                acc = acc - $signed(term);
            end else begin
                acc = acc + $signed(term);
            end
        end
        if (acc < 0) begin
            acc = '0;
        end
        if (acc > $signed(ONE_Q30)) begin
            acc = $signed(ONE_Q30);
        end
        return acc;
    endfunction

    function automatic logic [63:0] ln_q30(input logic [63:0] num, input logic [63:0] den_in);
        logic [63:0] den;
        logic [63:0] k;
        logic [63:0] z;
        logic [63:0] z2;
        logic [63:0] zp;
        logic [63:0] acc;
        den = den_in;
        k = '0;
        for (int j = 0; j < 8; j++) begin
            if (num >= 2 * den) begin
                den = den * 2;
                k = k + 1;
            end
        end
        z = udiv(((num - den) << 30) + ((num + den) >> 1), num + den);
        z2 = (z * z) >> 30;
        zp = z;
        acc = z;
        for (int n = 1; n <= 15; n++) begin
            zp = (zp * z2) >> 30;
            acc = acc + udiv(zp, 64'(2 * n + 1));
        end
        return k * LN2_Q30 + 2 * acc;
    endfunction

    function automatic t_curve_tab build_curve_tab();
        t_curve_tab t;
        logic [63:0] i;
        logic [63:0] v;
        for (int n = 0; n < 128; n++) begin
            i = 64'(n);
            t[0][n] = (TAB_BITS+1)'(udiv((i << TAB_BITS) + 64'd63, 64'd127));
            v = udiv((ln_q30(64'd127 + 64'd9 * i, 64'd127) << TAB_BITS) + (LN10_Q30 >> 1),
                     LN10_Q30);
            if (v > (64'd1 << TAB_BITS)) begin
                v = 64'd1 << TAB_BITS;
            end
            t[1][n] = (TAB_BITS+1)'(v);
            t[2][n] = (TAB_BITS+1)'(udiv(((i * i) << TAB_BITS) + 64'd8064, 64'd16129));
            v = sin_q30(udiv(HALF_PI_Q30 * i + 64'd63, 64'd127));
            v = (v * v + (64'd1 << 35)) >> 36;
            if (v > (64'd1 << TAB_BITS)) begin
                v = 64'd1 << TAB_BITS;
            end
            t[3][n] = (TAB_BITS+1)'(v);
        end
        for (int m = 0; m < 4; m++) begin
            t[m][0] = '0;
            t[m][127] = (TAB_BITS+1)'(1) << TAB_BITS;
        end
        return t;
    endfunction

    function automatic t_pos_tab build_pos_tab();
        t_pos_tab t;
        logic [63:0] v;
        for (int n = 0; n < 128; n++) begin
            v = udiv(64'(n) * 64'd65536 + 64'd63, 64'd127);
            if (v > 64'd65535) begin
                v = 64'd65535;
            end
            t[n] = 16'(v);
        end
        return t;
    endfunction

    localparam t_curve_tab CURVE_TAB = build_curve_tab();
    localparam t_pos_tab POS_TAB = build_pos_tab();

endpackage

@@ rtl/mccst_ctrl.sv @@
// Sequencing state machine for the MIDI CC mapper.
module mccst_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  mccst_pkg::t_status i_status,
    output logic              o_in_stall,
    output mccst_pkg::t_cmd    o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_EVAL,
        S_MUL,
        S_SUM,
        S_OUT
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state = r_state;
        o_cmd = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load_in = 1'b1;
                    n_state = S_EVAL;
                end
            end
            S_EVAL: begin
                o_cmd.eval = 1'b1;
                n_state = S_MUL;
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state = S_SUM;
            end
            S_SUM: begin
                o_cmd.sum = 1'b1;
                n_state = S_OUT;
            end
            S_OUT: begin
                if (i_status.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_in_stall = (r_state != S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

@@ rtl/mccst_dp.sv @@
// Datapath: configuration, source match, pickup state, curve lookup and range scaling.
module mccst_dp #(
    parameter int FRACTION_BITS = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  mccst_pkg::t_cmd                     i_cmd,
    output mccst_pkg::t_status                  o_status,
    input  logic                                i_cfg_valid,
    input  logic [mccst_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [mccst_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    input  logic                                i_is_controller,
    input  logic [3:0]                          i_event_channel,
    input  logic [6:0]                          i_event_number,
    input  logic [6:0]                          i_event_value,
    input  logic [15:0]                         i_current_param,
    input  logic                                i_out_stall,
    output logic                                o_out_valid,
    output logic                                o_matched,
    output logic                                o_write_valid,
    output logic signed [23:0]                  o_mapped_value,
    output logic                                o_position_notify,
    output logic [15:0]                         o_hardware_position
);

    localparam int TB = mccst_pkg::TAB_BITS;
    localparam int PW = FRACTION_BITS + 27;
    localparam logic signed [PW-1:0] RND_HALF = PW'(1) << (FRACTION_BITS - 1);

    // configuration
    logic [3:0]         r_src_ch;
    logic               r_src_cc;
    logic [6:0]         r_src_num;
    logic [1:0]         r_curve;
    logic               r_invert;
    logic signed [23:0] r_rlo;
    logic signed [23:0] r_rhi;
    logic               r_pickup;

    // pickup state
    logic        r_hooked;
    logic [15:0] r_last_pos;
    logic        r_last_known;

    // captured event
    logic        r_in_cc;
    logic [3:0]  r_in_ch;
    logic [6:0]  r_in_num;
    logic [6:0]  r_in_val;
    logic [15:0] r_in_cur;

    // pipeline
    logic [FRACTION_BITS:0] r_c;
    logic signed [24:0]     r_diff;
    logic                   r_match;
    logic                   r_wr;
    logic                   r_notify;
    logic [15:0]            r_pos;
    logic signed [PW-1:0]   r_prod;
    logic signed [23:0]     r_res;

    logic                   r_out_valid;
    logic                   r_out_matched;
    logic                   r_out_wr;
    logic signed [23:0]     r_out_val;
    logic                   r_out_notify;
    logic [15:0]            r_out_pos;

    // eval stage logic
    logic                   match;
    logic [15:0]            pos;
    logic [15:0]            prev_pos;
    logic [15:0]            pos_gap;
    logic                   crossed;
    logic                   near;
    logic                   waiting;
    logic [6:0]             idx;
    logic [TB:0]            tab;
    logic [TB+2:0]          tab_rnd;
    logic signed [PW-1:0]   rnd;
    logic signed [26:0]     tot;
    logic signed [23:0]     sat;
    logic                   src_write;

    assign match = !(!r_in_cc && (r_in_val == 7'd0)) && (r_in_cc == r_src_cc) &&
                   (r_in_ch == r_src_ch) && (r_in_num == r_src_num);
    assign pos = mccst_pkg::POS_TAB[r_in_val];
    assign prev_pos = r_last_known ? r_last_pos : pos;
    assign pos_gap = (pos > r_in_cur) ? (pos - r_in_cur) : (r_in_cur - pos);
    assign crossed = ((prev_pos <= r_in_cur) && (pos >= r_in_cur)) ||
                     ((prev_pos >= r_in_cur) && (pos <= r_in_cur));
    assign near = (({5'd0, pos_gap} * 21'd20) < 21'd65536);
    assign waiting = r_pickup && !r_hooked;
    assign idx = r_invert ? ~r_in_val : r_in_val;
    assign tab = mccst_pkg::CURVE_TAB[r_curve][idx];
    assign tab_rnd = ({1'b0, tab, 1'b0} >> (TB - FRACTION_BITS)) + (TB+3)'(1);

    assign rnd = (r_prod + RND_HALF) >>> FRACTION_BITS;
    assign tot = $signed(rnd[26:0]) + $signed({{3{r_rlo[23]}}, r_rlo});

    always_comb begin
        if (tot < -27'sd8388608) begin
            sat = 24'sh800000;
        end else if (tot > 27'sd8388607) begin
            sat = 24'sh7FFFFF;
        end else begin
            sat = tot[23:0];
        end
    end

    assign src_write = i_cfg_valid && ((i_cfg_index == mccst_pkg::CFG_SOURCE_CHANNEL) ||
                                       (i_cfg_index == mccst_pkg::CFG_SOURCE_IS_CC) ||
                                       (i_cfg_index == mccst_pkg::CFG_SOURCE_NUMBER));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_src_ch <= '0;
            r_src_cc <= 1'b1;
            r_src_num <= '0;
            r_curve <= '0;
            r_invert <= 1'b0;
            r_rlo <= '0;
            r_rhi <= 24'sd65536;
            r_pickup <= 1'b0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                mccst_pkg::CFG_SOURCE_CHANNEL: r_src_ch <= i_cfg_data[3:0];
                mccst_pkg::CFG_SOURCE_IS_CC:   r_src_cc <= i_cfg_data[0];
                mccst_pkg::CFG_SOURCE_NUMBER:  r_src_num <= i_cfg_data[6:0];
                mccst_pkg::CFG_CURVE_MODE:     r_curve <= i_cfg_data[1:0];
                mccst_pkg::CFG_INVERT_ENABLE:  r_invert <= i_cfg_data[0];
                mccst_pkg::CFG_RANGE_LOW:      r_rlo <= $signed(i_cfg_data);
                mccst_pkg::CFG_RANGE_HIGH:     r_rhi <= $signed(i_cfg_data);
                mccst_pkg::CFG_PICKUP_ENABLE:  r_pickup <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hooked <= 1'b0;
            r_last_pos <= '0;
            r_last_known <= 1'b0;
        end else if (src_write) begin
            r_hooked <= 1'b0;
            r_last_known <= 1'b0;
        end else if (i_cmd.eval && match && waiting) begin
            r_last_pos <= pos;
            r_last_known <= 1'b1;
            if (crossed || near) begin
                r_hooked <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_in_cc <= i_is_controller;
            r_in_ch <= i_event_channel;
            r_in_num <= i_event_number;
            r_in_val <= i_event_value;
            r_in_cur <= i_current_param;
        end
        if (i_cmd.eval) begin
            r_match <= match;
            r_pos <= match ? pos : 16'd0;
            r_notify <= match && waiting && !(crossed || near);
            r_wr <= match && !(waiting && !(crossed || near));
            r_c <= tab_rnd[FRACTION_BITS+1:1];
            r_diff <= $signed({r_rhi[23], r_rhi}) - $signed({r_rlo[23], r_rlo});
        end
        if (i_cmd.mul) begin
            r_prod <= $signed({1'b0, r_c}) * r_diff;
        end
        if (i_cmd.sum) begin
            r_res <= sat;
        end
    end

    assign o_status.out_free = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_out_matched <= r_match;
            r_out_wr <= r_wr;
            r_out_val <= r_wr ? r_res : 24'sd0;
            r_out_notify <= r_notify;
            r_out_pos <= r_pos;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_matched = r_out_matched;
    assign o_write_valid = r_out_wr;
    assign o_mapped_value = r_out_val;
    assign o_position_notify = r_out_notify;
    assign o_hardware_position = r_out_pos;

endmodule

@@ rtl/midi_cc_soft_takeover_mapper.sv @@
// Top level of the MIDI CC / note-on soft takeover mapper.
// Each event is captured, then stepped by the sequencer through eval, multiply, sum and output.
// A new event is taken only once the previous result has been loaded into the output register.
// The output register frees the pipeline: a new event is taken while a result still waits.
// Reset (synchronous, active low) restores register defaults and clears the pickup state.
module midi_cc_soft_takeover_mapper #(
    parameter int FRACTION_BITS = 16
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [mccst_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [mccst_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  logic                             i_is_controller,
    input  logic [3:0]                       i_event_channel,
    input  logic [6:0]                       i_event_number,
    input  logic [6:0]                       i_event_value,
    input  logic [15:0]                      i_current_param,
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output logic                             o_matched,
    output logic                             o_write_valid,
    output logic signed [23:0]               o_mapped_value,
    output logic                             o_position_notify,
    output logic [15:0]                      o_hardware_position
);

    mccst_pkg::t_cmd    cmd;
    mccst_pkg::t_status status;

    assign o_cfg_ready = 1'b1;

    mccst_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_status   (status),
        .o_in_stall (o_in_stall),
        .o_cmd      (cmd)
    );

    mccst_dp #(
        .FRACTION_BITS (FRACTION_BITS)
    ) u_dp (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cmd               (cmd),
        .o_status            (status),
        .i_cfg_valid         (i_cfg_valid),
        .i_cfg_index         (i_cfg_index),
        .i_cfg_data          (i_cfg_data),
        .i_is_controller     (i_is_controller),
        .i_event_channel     (i_event_channel),
        .i_event_number      (i_event_number),
        .i_event_value       (i_event_value),
        .i_current_param     (i_current_param),
        .i_out_stall         (i_out_stall),
        .o_out_valid         (o_out_valid),
        .o_matched           (o_matched),
        .o_write_valid       (o_write_valid),
        .o_mapped_value      (o_mapped_value),
        .o_position_notify   (o_position_notify),
        .o_hardware_position (o_hardware_position)
    );

endmodule

@@ dv/tb_midi_cc_soft_takeover_mapper.sv @@
// Self-checking testbench for the MIDI CC soft takeover mapper: directed and random events.
module tb_midi_cc_soft_takeover_mapper;

    localparam int FRAC_BITS = 16;
    localparam int LUT_BITS = 24;
    localparam int N_ITEMS = 1600;
    localparam int HOLD_CYCLES = 120;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int SETTLE_CYCLES = 20;
    localparam int DRAIN_CYCLES = 6;
    localparam int CFG_REGS = 8;

    localparam logic KIND_NOTE = 1'b0;
    localparam logic KIND_CC = 1'b1;
    localparam logic [1:0] CURVE_LINEAR = 2'd0;
    localparam logic [1:0] CURVE_LOG = 2'd1;
    localparam logic [1:0] CURVE_SQUARE = 2'd2;
    localparam logic [1:0] CURVE_COSINE = 2'd3;
    localparam logic [23:0] RANGE_MIN = 24'h800000;
    localparam logic [23:0] RANGE_MAX = 24'h7FFFFF;
    localparam longint MAPPED_MIN = -8388608;
    localparam longint MAPPED_MAX = 8388607;

    typedef longint unsigned u64_t;

    localparam u64_t Q30_ONE = 64'd1073741824;
    localparam u64_t Q30_HALF_PI = 64'd1686629713;
    localparam u64_t Q30_LN2 = 64'd744261118;
    localparam u64_t Q30_LN10 = 64'd2472381918;

    typedef struct packed {
        logic        is_cc;
        logic [3:0]  channel;
        logic [6:0]  number;
        logic [6:0]  value;
        logic [15:0] cur_param;
    } midi_event_t;

    typedef struct packed {
        logic        matched;
        logic        wr;
        logic [23:0] mapped;
        logic        notify;
        logic [15:0] hw_pos;
    } mapping_t;

    class takeover_scoreboard;
        u64_t curve_lut[4][128];
        logic [3:0] src_channel;
        logic src_is_cc;
        logic [6:0] src_number;
        logic [1:0] curve_sel;
        logic invert_on;
        logic signed [23:0] range_lo;
        logic signed [23:0] range_hi;
        logic pickup_on;
        logic hooked;
        logic [15:0] last_pos;
        logic last_pos_known;
        mapping_t expected_q[$];
        int errors;

        function new();
            u64_t i;
            u64_t v;
            for (i = 0; i < 128; i++) begin
                curve_lut[CURVE_LINEAR][i] = ((i << LUT_BITS) + 63) / 127;
                v = ((log_series(127 + 9 * i, 127) << LUT_BITS) + Q30_LN10 / 2) / Q30_LN10;
                if (v > (u64_t'(1) << LUT_BITS)) v = u64_t'(1) << LUT_BITS;
                curve_lut[CURVE_LOG][i] = v;
                curve_lut[CURVE_SQUARE][i] = (((i * i) << LUT_BITS) + 8064) / 16129;
                v = sine_series((Q30_HALF_PI * i + 63) / 127);
                v = (v * v + (u64_t'(1) << 35)) >> 36;
                if (v > (u64_t'(1) << LUT_BITS)) v = u64_t'(1) << LUT_BITS;
                curve_lut[CURVE_COSINE][i] = v;
            end
            for (i = 0; i < 4; i++) begin
                curve_lut[i][0] = 0;
                curve_lut[i][127] = u64_t'(1) << LUT_BITS;
            end
            src_channel = '0;
            src_is_cc = KIND_CC;
            src_number = '0;
            curve_sel = CURVE_LINEAR;
            invert_on = 1'b0;
            range_lo = '0;
            range_hi = 24'sd65536;
            pickup_on = 1'b0;
            hooked = 1'b0;
            last_pos = '0;
            last_pos_known = 1'b0;
            errors = 0;
        endfunction

        function u64_t sine_series(u64_t a);
            u64_t a2;
            u64_t term;
            longint acc;
            int k;
            a2 = (a * a) >> 30;
            term = a;
            acc = longint'(a);
            for (k = 1; k <= 8; k++) begin
                term = (term * a2) >> 30;
                term = term / u64_t'((2 * k) * (2 * k + 1));
                if (k % 2 == 1) acc -= longint'(term);
                else acc += longint'(term);
            end
            if (acc < 0) acc = 0;
            if (acc > longint'(Q30_ONE)) acc = longint'(Q30_ONE);
            return u64_t'(acc);
        endfunction

        // ln(num/den) in Q30: power-of-two reduction, then atanh series
        function u64_t log_series(u64_t num, u64_t den);
            u64_t k;
            u64_t z;
            u64_t z2;
            u64_t zp;
            u64_t acc;
            int n;
            k = 0;
            while (num >= 2 * den) begin
                den = den * 2;
                k++;
            end
            z = (((num - den) << 30) + (num + den) / 2) / (num + den);
            z2 = (z * z) >> 30;
            zp = z;
            acc = z;
            for (n = 1; n <= 15; n++) begin
                zp = (zp * z2) >> 30;
                acc += zp / u64_t'(2 * n + 1);
            end
            return k * Q30_LN2 + 2 * acc;
        endfunction

        function void write_register(logic [mccst_pkg::CFG_IDX_W-1:0] idx,
                                     logic [mccst_pkg::CFG_DATA_W-1:0] data);
            case (idx)
                mccst_pkg::CFG_SOURCE_CHANNEL: src_channel = data[3:0];
                mccst_pkg::CFG_SOURCE_IS_CC:   src_is_cc = data[0];
                mccst_pkg::CFG_SOURCE_NUMBER:  src_number = data[6:0];
                mccst_pkg::CFG_CURVE_MODE:     curve_sel = data[1:0];
                mccst_pkg::CFG_INVERT_ENABLE:  invert_on = data[0];
                mccst_pkg::CFG_RANGE_LOW:      range_lo = data;
                mccst_pkg::CFG_RANGE_HIGH:     range_hi = data;
                mccst_pkg::CFG_PICKUP_ENABLE:  pickup_on = data[0];
                default: return;
            endcase
            // a new source re-arms the takeover
            if (idx <= mccst_pkg::CFG_SOURCE_NUMBER) begin
                hooked = 1'b0;
                last_pos_known = 1'b0;
            end
        endfunction

        function void note_event(midi_event_t ev);
            mapping_t res;
            u64_t pos;
            u64_t gap_abs;
            logic [6:0] idx;
            longint c;
            longint p;
            longint r;
            bit crossed;
            bit close_by;
            res = '0;
            // note-on with velocity zero is a note-off
            if ((ev.is_cc || ev.value != 0) && ev.is_cc == src_is_cc &&
                ev.channel == src_channel && ev.number == src_number) begin
                pos = (u64_t'(ev.value) * 65536 + 63) / 127;
                if (pos > 65535) pos = 65535;
                res.matched = 1'b1;
                res.hw_pos = pos[15:0];
                if (pickup_on && !hooked) begin
                    if (!last_pos_known) begin
                        last_pos = pos[15:0];
                        last_pos_known = 1'b1;
                    end
                    crossed = (last_pos <= ev.cur_param && pos >= ev.cur_param) ||
                              (last_pos >= ev.cur_param && pos <= ev.cur_param);
                    gap_abs = pos > ev.cur_param ? pos - ev.cur_param : ev.cur_param - pos;
                    close_by = 20 * gap_abs < 65536;
                    last_pos = pos[15:0];
                    if (crossed || close_by) hooked = 1'b1;
                    else res.notify = 1'b1;
                end
                if (!res.notify) begin
                    idx = invert_on ? 7'd127 - ev.value : ev.value;
                    c = longint'((((curve_lut[curve_sel][idx] << 1) >>
                                   (LUT_BITS - FRAC_BITS)) + 1) >> 1);
                    p = c * (longint'(range_hi) - longint'(range_lo));
                    r = longint'(range_lo) + ((p + (longint'(1) << (FRAC_BITS - 1))) >>> FRAC_BITS);
                    if (r < MAPPED_MIN) r = MAPPED_MIN;
                    if (r > MAPPED_MAX) r = MAPPED_MAX;
                    res.wr = 1'b1;
                    res.mapped = r[23:0];
                end
            end
            expected_q = {expected_q, res};
        endfunction

        function void compare_field(string name, logic [23:0] want, logic [23:0] got);
            if (want !== got) begin
                $display("%0t: %s expected %h actual %h", $time, name, want, got);
                errors++;
            end
        endfunction

        function void check_result(mapping_t got);
            mapping_t want;
            if (expected_q.size() == 0) begin
                $display("%0t: result with no event pending, expected none, actual %h", $time, got);
                errors++;
                return;
            end
            want = expected_q.pop_front();
            compare_field("matched", want.matched, got.matched);
            compare_field("write_valid", want.wr, got.wr);
            compare_field("mapped_value", want.mapped, got.mapped);
            compare_field("position_notify", want.notify, got.notify);
            compare_field("hardware_position", want.hw_pos, got.hw_pos);
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic i_cfg_valid;
    logic o_cfg_ready;
    logic [mccst_pkg::CFG_IDX_W-1:0] i_cfg_index;
    logic [mccst_pkg::CFG_DATA_W-1:0] i_cfg_data;
    logic i_in_valid;
    logic o_in_stall;
    logic i_is_controller;
    logic [3:0] i_event_channel;
    logic [6:0] i_event_number;
    logic [6:0] i_event_value;
    logic [15:0] i_current_param;
    logic o_out_valid;
    logic i_out_stall;
    logic o_matched;
    logic o_write_valid;
    logic signed [23:0] o_mapped_value;
    logic o_position_notify;
    logic [15:0] o_hardware_position;

    takeover_scoreboard sb;
    int sent_events = 0;
    int idle_cycles = 0;
    logic hold_req = 1'b0;
    logic sender_burst = 1'b0;

    wire in_xfer = i_in_valid && !o_in_stall;
    wire out_xfer = o_out_valid && !i_out_stall;
    wire cfg_xfer = i_cfg_valid && o_cfg_ready;

    midi_cc_soft_takeover_mapper #(
        .FRACTION_BITS(FRAC_BITS)
    ) u_top (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data(i_cfg_data),
        .i_in_valid(i_in_valid),
        .o_in_stall(o_in_stall),
        .i_is_controller(i_is_controller),
        .i_event_channel(i_event_channel),
        .i_event_number(i_event_number),
        .i_event_value(i_event_value),
        .i_current_param(i_current_param),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_matched(o_matched),
        .o_write_valid(o_write_valid),
        .o_mapped_value(o_mapped_value),
        .o_position_notify(o_position_notify),
        .o_hardware_position(o_hardware_position)
    );

    always #6 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (out_xfer) begin
                sb.check_result({o_matched, o_write_valid, o_mapped_value,
                                 o_position_notify, o_hardware_position});
            end
            if (in_xfer) begin
                sb.note_event({i_is_controller, i_event_channel, i_event_number,
                               i_event_value, i_current_param});
                sent_events++;
            end
            if (cfg_xfer) begin
                sb.write_register(i_cfg_index, i_cfg_data);
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || in_xfer || out_xfer || cfg_xfer) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no transfer for %0d cycles", $time, idle_cycles);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // result side: short and long stalls, calm stretches, one long hold-off on request
    initial begin : result_stall
        int stall_left;
        int calm_left;
        int r;
        stall_left = 0;
        calm_left = 0;
        i_out_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                hold_req = 1'b0;
                stall_left = HOLD_CYCLES;
            end else if (stall_left == 0) begin
                if (calm_left > 0) begin
                    calm_left--;
                end else begin
                    r = $urandom_range(0, 99);
                    if (r < 3) calm_left = $urandom_range(40, 150);
                    else if (r < 25) stall_left = $urandom_range(1, 3);
                    else if (r < 28) stall_left = $urandom_range(8, 40);
                end
            end
            i_out_stall <= (stall_left > 0);
            if (stall_left > 0) stall_left--;
        end
    end

    function automatic midi_event_t make_event(logic kind, logic [3:0] ch, logic [6:0] num,
                                               logic [6:0] val, logic [15:0] cur);
        return {kind, ch, num, val, cur};
    endfunction

    function automatic logic [23:0] pick_range();
        case ($urandom_range(0, 7))
            0: return RANGE_MIN;
            1: return RANGE_MAX;
            2: return 24'd0;
            3: return 24'd65536;
            default: return 24'($urandom());
        endcase
    endfunction

    // called at a falling edge, returns at a falling edge
    task automatic drive_event(input midi_event_t ev);
        int gap;
        int r;
        i_in_valid <= 1'b1;
        i_is_controller <= ev.is_cc;
        i_event_channel <= ev.channel;
        i_event_number <= ev.number;
        i_event_value <= ev.value;
        i_current_param <= ev.cur_param;
        do @(posedge i_clk); while (o_in_stall);
        @(negedge i_clk);
        r = $urandom_range(0, 99);
        if (sender_burst || r < 60) gap = 0;
        else if (r < 90) gap = $urandom_range(1, 3);
        else gap = $urandom_range(5, 30);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
    endtask

    task automatic write_reg(input logic [mccst_pkg::CFG_IDX_W-1:0] idx,
                             input logic [mccst_pkg::CFG_DATA_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (sb.pending() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    initial begin : stimulus
        midi_event_t ev;
        logic [63:0] rnd;
        logic [15:0] cur;
        logic down;
        int walk;
        int step;
        int next_walk;
        int n;
        int pick;
        int phase_no;

        sb = new();
        i_rst_n = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_index = '0;
        i_cfg_data = '0;
        i_in_valid = 1'b0;
        i_is_controller = 1'b0;
        i_event_channel = '0;
        i_event_number = '0;
        i_event_value = '0;
        i_current_param = '0;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset mapping: CC 0 on channel 0, linear, 0..1.0
        drive_event(make_event(KIND_CC, 4'd0, 7'd0, 7'd0, 16'h0000));
        drive_event(make_event(KIND_CC, 4'd0, 7'd0, 7'd127, 16'hFFFF));
        drive_event(make_event(KIND_CC, 4'd0, 7'd0, 7'd64, 16'h8000));
        drive_event(make_event(KIND_CC, 4'd15, 7'd127, 7'd127, 16'h1234));
        drive_event(make_event(KIND_NOTE, 4'd0, 7'd0, 7'd127, 16'h0000));
        drive_event(make_event(KIND_NOTE, 4'd0, 7'd0, 7'd0, 16'h0000));
        wait_drained();

        write_reg(mccst_pkg::CFG_SOURCE_IS_CC, mccst_pkg::CFG_DATA_W'(KIND_NOTE));
        write_reg(mccst_pkg::CFG_SOURCE_CHANNEL, 24'd15);
        write_reg(mccst_pkg::CFG_SOURCE_NUMBER, 24'd127);
        write_reg(mccst_pkg::CFG_CURVE_MODE, mccst_pkg::CFG_DATA_W'(CURVE_COSINE));
        write_reg(mccst_pkg::CFG_INVERT_ENABLE, 24'd1);
        write_reg(mccst_pkg::CFG_RANGE_LOW, RANGE_MIN);
        write_reg(mccst_pkg::CFG_RANGE_HIGH, RANGE_MAX);
        drive_event(make_event(KIND_NOTE, 4'd15, 7'd127, 7'd0, 16'h0000));
        drive_event(make_event(KIND_NOTE, 4'd15, 7'd127, 7'd1, 16'hFFFF));
        drive_event(make_event(KIND_NOTE, 4'd15, 7'd127, 7'd127, 16'h0000));
        drive_event(make_event(KIND_CC, 4'd15, 7'd127, 7'd50, 16'h0000));
        wait_drained();

        write_reg(mccst_pkg::CFG_CURVE_MODE, mccst_pkg::CFG_DATA_W'(CURVE_LOG));
        write_reg(mccst_pkg::CFG_INVERT_ENABLE, 24'd0);
        drive_event(make_event(KIND_NOTE, 4'd15, 7'd127, 7'd127, 16'h0000));
        drive_event(make_event(KIND_NOTE, 4'd15, 7'd127, 7'd63, 16'h0000));
        wait_drained();

        // reversed range scales downward
        write_reg(mccst_pkg::CFG_CURVE_MODE, mccst_pkg::CFG_DATA_W'(CURVE_SQUARE));
        write_reg(mccst_pkg::CFG_RANGE_LOW, RANGE_MAX);
        write_reg(mccst_pkg::CFG_RANGE_HIGH, RANGE_MIN);
        drive_event(make_event(KIND_NOTE, 4'd15, 7'd127, 7'd100, 16'h0000));
        drive_event(make_event(KIND_NOTE, 4'd15, 7'd127, 7'd1, 16'h0000));
        wait_drained();

        // takeover: first position far off, then an upward crossing, then hooked
        write_reg(mccst_pkg::CFG_PICKUP_ENABLE, 24'd1);
        write_reg(mccst_pkg::CFG_SOURCE_NUMBER, 24'd127);
        drive_event(make_event(KIND_NOTE, 4'd15, 7'd127, 7'd1, 16'h8000));
        drive_event(make_event(KIND_NOTE, 4'd15, 7'd127, 7'd10, 16'h8000));
        drive_event(make_event(KIND_NOTE, 4'd15, 7'd127, 7'd127, 16'h8000));
        drive_event(make_event(KIND_NOTE, 4'd15, 7'd127, 7'd5, 16'h8000));
        wait_drained();

        // hooks on closeness at the first event
        write_reg(mccst_pkg::CFG_SOURCE_CHANNEL, 24'd15);
        drive_event(make_event(KIND_NOTE, 4'd15, 7'd127, 7'd64, 16'd33000));
        wait_drained();

        // downward crossing
        write_reg(mccst_pkg::CFG_SOURCE_NUMBER, 24'd127);
        drive_event(make_event(KIND_NOTE, 4'd15, 7'd127, 7'd127, 16'h4000));
        drive_event(make_event(KIND_NOTE, 4'd15, 7'd127, 7'd1, 16'h4000));
        wait_drained();

        write_reg(mccst_pkg::CFG_PICKUP_ENABLE, 24'd0);
        drive_event(make_event(KIND_NOTE, 4'd15, 7'd127, 7'd30, 16'h0000));

        phase_no = 0;
        while (sent_events < N_ITEMS) begin
            wait_drained();
            if ($urandom_range(0, 1)) begin
                write_reg(mccst_pkg::CFG_SOURCE_CHANNEL, mccst_pkg::CFG_DATA_W'($urandom()));
            end
            if ($urandom_range(0, 1)) begin
                write_reg(mccst_pkg::CFG_SOURCE_IS_CC, mccst_pkg::CFG_DATA_W'($urandom()));
            end
            if ($urandom_range(0, 1)) begin
                write_reg(mccst_pkg::CFG_SOURCE_NUMBER, mccst_pkg::CFG_DATA_W'($urandom()));
            end
            if ($urandom_range(0, 1)) begin
                write_reg(mccst_pkg::CFG_CURVE_MODE, mccst_pkg::CFG_DATA_W'($urandom()));
            end
            if ($urandom_range(0, 1)) begin
                write_reg(mccst_pkg::CFG_INVERT_ENABLE, mccst_pkg::CFG_DATA_W'($urandom()));
            end
            if ($urandom_range(0, 1)) write_reg(mccst_pkg::CFG_RANGE_LOW, pick_range());
            if ($urandom_range(0, 1)) write_reg(mccst_pkg::CFG_RANGE_HIGH, pick_range());
            if ($urandom_range(0, 1)) begin
                write_reg(mccst_pkg::CFG_PICKUP_ENABLE, mccst_pkg::CFG_DATA_W'($urandom()));
            end
            if ($urandom_range(0, 3) == 0) begin
                write_reg(mccst_pkg::CFG_IDX_W'($urandom_range(CFG_REGS,
                                                               2 ** mccst_pkg::CFG_IDX_W - 1)),
                          mccst_pkg::CFG_DATA_W'($urandom()));
            end

            sender_burst = ($urandom_range(0, 3) == 0) || phase_no == 2;
            if (phase_no == 2) hold_req = 1'b1;

            case ($urandom_range(0, 5))
                0: cur = 16'h0000;
                1: cur = 16'hFFFF;
                default: cur = 16'($urandom());
            endcase
            walk = $urandom_range(0, 127);
            step = $urandom_range(1, 12);
            down = 1'($urandom_range(0, 1));
            n = $urandom_range(20, 60);
            // knob sweeps on the source with the odd jump, plus near misses and noise
            repeat (n) begin
                pick = $urandom_range(0, 9);
                if (pick < 8) begin
                    if ($urandom_range(0, 7) == 0) begin
                        walk = $urandom_range(0, 127);
                    end else begin
                        next_walk = down ? walk - step : walk + step;
                        if (next_walk < 0) begin
                            next_walk = 0;
                            down = 1'b0;
                        end
                        if (next_walk > 127) begin
                            next_walk = 127;
                            down = 1'b1;
                        end
                        walk = next_walk;
                    end
                    if ($urandom_range(0, 7) == 0) cur = 16'($urandom());
                    ev = make_event(sb.src_is_cc, sb.src_channel, sb.src_number, 7'(walk), cur);
                end else if (pick == 8) begin
                    ev = make_event(sb.src_is_cc, sb.src_channel, sb.src_number,
                                    7'($urandom()), 16'($urandom()));
                    case ($urandom_range(0, 2))
                        0: ev.is_cc = ~ev.is_cc;
                        1: ev.channel = 4'($urandom());
                        default: ev.number = 7'($urandom());
                    endcase
                end else begin
                    rnd = {$urandom(), $urandom()};
                    ev = rnd[$bits(midi_event_t)-1:0];
                end
                drive_event(ev);
            end
            phase_no++;
        end

        i_in_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (sb.errors == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

@@ files.f @@
rtl/mccst_pkg.sv
rtl/mccst_ctrl.sv
rtl/mccst_dp.sv
rtl/midi_cc_soft_takeover_mapper.sv
dv/tb_midi_cc_soft_takeover_mapper.sv
